// File: design/rset_pkg.sv
`timescale 1ns / 1ps
package rset_pkg;

  localparam int unsigned ReqW  = 2;
  localparam int unsigned ValW  = 32;
  localparam int unsigned RndW  = 16;
  localparam int unsigned OccW  = 7;
  localparam int unsigned StepW = $clog2(RndW);

  // Request kinds.
  localparam logic [ReqW-1:0] REQ_INSERT = 2'd0;
  localparam logic [ReqW-1:0] REQ_REMOVE = 2'd1;
  localparam logic [ReqW-1:0] REQ_SAMPLE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RM_RD,
    S_RM_WR,
    S_DIV,
    S_SM_RD,
    S_DONE
  } state_e;

endpackage

// File: design/rset_mod.sv
`timescale 1ns / 1ps
// Restoring remainder unit: one dividend bit per cycle.
module rset_mod #(
  parameter int unsigned CntW = 7
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rset_pkg::RndW-1:0] dividend_i,
  input  logic [CntW-1:0]          divisor_i,
  output logic                     done_o,
  output logic [CntW-1:0]          rem_o
);
  import rset_pkg::*;

  localparam logic [StepW-1:0] LastStep = StepW'(RndW - 1);

  logic              busy_q, done_q;
  logic [StepW-1:0]  step_q;
  logic [RndW-1:0]   dvd_q;
  logic [CntW-1:0]   dvs_q;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [CntW:0]     shifted;

  always_comb begin
    shifted = {rem_q, dvd_q[RndW-1]};
    if (shifted >= {1'b0, dvs_q}) begin
      rem_d = CntW'(shifted - {1'b0, dvs_q});
    end else begin
      rem_d = shifted[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RndW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: design/randomized_set_table_top.sv
`timescale 1ns / 1ps
// Set of distinct 32-bit values kept densely packed in a store with one write port and one read port.
// Input channel (in_valid_i / in_stall_o) carries one request per transfer:
// insert, remove or sample. Output channel (out_valid_o / out_stall_i) returns
// exactly one result per request: ok flag, sampled value, and the member
// count after the request.
// Insert and remove scan the occupied entries one per cycle through the
// store's read port; a remove that hits then does a read and a write to move
// the last entry into the hole. Sample runs a 16-step restoring remainder of
// random_word by count, then one store read. Failures detected up front (full,
// empty, unused kind) go straight to the result stage. One request is in flight
// at a time; in_stall_o is high from the transfer until the result is handed
// to the output register, so the next transfer comes in the cycle after that
// at the earliest.
// The output register holds a result while out_stall_i is high; the block
// already accepts the next request meanwhile, but cannot finish it until the
// register is free.
// Reset clears the member count and all control; store contents need none.
module randomized_set_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [rset_pkg::ReqW-1:0]        req_type_i,
  input  logic signed [rset_pkg::ValW-1:0] value_i,
  input  logic [rset_pkg::RndW-1:0]        random_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic signed [rset_pkg::ValW-1:0] sample_value_o,
  output logic [rset_pkg::OccW-1:0]        occupancy_o
);
  import rset_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);

  // Member store: one write and one registered read per cycle.
  logic [ValW-1:0]  mem_q [CAPACITY];
  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [ValW-1:0]  wr_data, rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Control state.
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            cmp_valid_q, cmp_valid_d;
  logic            out_valid_q, out_valid_d;

  // Request and result payload.
  logic [ReqW-1:0]  kind_q;
  logic [ValW-1:0]  key_q;
  logic [RndW-1:0]  rnd_q;
  logic [AddrW-1:0] cmp_idx_q, pos_q, pos_d;
  logic             res_ok_q, res_ok_d;
  logic [ValW-1:0]  res_val_q, res_val_d;
  logic             ok_q;
  logic [ValW-1:0]  sample_q;
  logic [OccW-1:0]  occ_q;

  logic            accept, load_out, hit;
  logic            div_start, div_done;
  logic [CntW-1:0] div_rem;
  logic [CntW-1:0] last_idx;
  logic [CntW+OccW-1:0] occ_ext;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign hit      = cmp_valid_q && (rd_data_q == key_q);
  assign last_idx = count_q - 1'b1;
  assign occ_ext  = {{OccW{1'b0}}, count_q};

  rset_mod #(
    .CntW(CntW)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rnd_q),
    .divisor_i (count_q),
    .done_o    (div_done),
    .rem_o     (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    cmp_valid_d = 1'b0;
    pos_d       = pos_q;
    res_ok_d    = res_ok_q;
    res_val_d   = res_val_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q[AddrW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[AddrW-1:0];
    wr_data     = key_q;
    div_start   = 1'b0;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        res_ok_d  = 1'b0;
        res_val_d = '0;
        scan_d    = '0;
        if (accept) begin
          priority if (req_type_i == REQ_INSERT) begin
            state_d = (count_q == CapC) ? S_DONE : S_SCAN;
          end else if (req_type_i == REQ_REMOVE) begin
            state_d = S_SCAN;
          end else if (req_type_i == REQ_SAMPLE) begin
            state_d = (count_q == '0) ? S_DONE : S_DIV;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // Compare the entry read last cycle while the next read is issued.
        priority if (hit) begin
          if (kind_q == REQ_INSERT) begin
            state_d = S_DONE;
          end else begin
            pos_d   = cmp_idx_q;
            state_d = S_RM_RD;
          end
        end else if (scan_q == count_q) begin
          if (kind_q == REQ_INSERT) begin
            wr_en    = 1'b1;
            count_d  = count_q + 1'b1;
            res_ok_d = 1'b1;
          end
          state_d = S_DONE;
        end else begin
          rd_en       = 1'b1;
          cmp_valid_d = 1'b1;
          scan_d      = scan_q + 1'b1;
        end
      end

      S_RM_RD: begin
        rd_en   = 1'b1;
        rd_addr = last_idx[AddrW-1:0];
        state_d = S_RM_WR;
      end

      S_RM_WR: begin
        // Move the last entry into the hole.
        wr_en    = 1'b1;
        wr_addr  = pos_q;
        wr_data  = rd_data_q;
        count_d  = last_idx;
        res_ok_d = 1'b1;
        state_d  = S_DONE;
      end

      S_DIV: begin
        div_start = (scan_q == '0);
        scan_d    = {{(CntW-1){1'b0}}, 1'b1};
        if (div_done) begin
          rd_en   = 1'b1;
          rd_addr = div_rem[AddrW-1:0];
          state_d = S_SM_RD;
        end
      end

      S_SM_RD: begin
        res_ok_d  = 1'b1;
        res_val_d = rd_data_q;
        state_d   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      cmp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      cmp_valid_q <= cmp_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= req_type_i;
      key_q  <= value_i;
      rnd_q  <= random_word_i;
    end
    cmp_idx_q <= scan_q[AddrW-1:0];
    pos_q     <= pos_d;
    res_ok_q  <= res_ok_d;
    res_val_q <= res_val_d;
    if (load_out) begin
      ok_q     <= res_ok_q;
      sample_q <= res_val_q;
      occ_q    <= occ_ext[OccW-1:0];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign ok_o           = ok_q;
  assign sample_value_o = sample_q;
  assign occupancy_o    = occ_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("member count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + 1'b1 || count_q + 1'b1 == $past(count_q)))
    else $error("member count moved by more than one");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !ok_o) |-> (sample_value_o == '0))
    else $error("failed request carries a nonzero sample");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == S_SCAN || state_q == S_RM_WR))
    else $error("store written outside insert or remove");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rset_pkg::*;

  localparam int unsigned SET_CAP    = 64;
  localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int unsigned DRAIN_WAIT = 120;   // covers a full scan plus the output stage
  // Request kind 3 is not decoded by the block; it must answer ok=0.
  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;

  // What one transfer on the result side carries.
  typedef struct packed {
    logic            ok;
    logic [ValW-1:0] sample_value;
    logic [OccW-1:0] occupancy;
  } answer_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    in_valid_i    = 1'b0;
  logic                    in_stall_o;
  logic [ReqW-1:0]         req_type_i    = '0;
  logic signed [ValW-1:0]  value_i       = '0;
  logic [RndW-1:0]         random_word_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i   = 1'b0;
  logic                    ok_o;
  logic signed [ValW-1:0]  sample_value_o;
  logic [OccW-1:0]         occupancy_o;

  // Shadow copy of the set: dense members plus the live count.
  logic [ValW-1:0] set_vals [SET_CAP];
  int              set_size = 0;
  answer_t         answer_q [$];

  int fail_count     = 0;
  int send_gap_pct   = 0;  // chance per cycle that the request side holds off
  int recv_stall_pct = 0;  // chance per cycle that the result side stalls
  int quiet_cycles   = 0;

  randomized_set_table_top #(
    .CAPACITY(SET_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .random_word_i (random_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ok_o          (ok_o),
    .sample_value_o(sample_value_o),
    .occupancy_o   (occupancy_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one request to the shadow set and return the answer it must give.
  // Membership compares raw 32-bit patterns, so signedness plays no part.
  function automatic answer_t apply_request(logic [ReqW-1:0] kind, logic [ValW-1:0] key,
                                            logic [RndW-1:0] rnd);
    answer_t ans;
    int      hit;
    ans = '0;
    hit = -1;
    for (int i = 0; i < set_size; i++) begin
      if (hit < 0 && set_vals[i] == key) hit = i;
    end
    case (kind)
      REQ_INSERT: begin
        // Reject duplicates and a full store; otherwise append at the end.
        if (set_size < SET_CAP && hit < 0) begin
          set_vals[set_size] = key;
          set_size++;
          ans.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        // Fill the hole with the last member, then shrink the count.
        if (hit >= 0) begin
          set_vals[hit] = set_vals[set_size-1];
          set_size--;
          ans.ok = 1'b1;
        end
      end
      REQ_SAMPLE: begin
        if (set_size > 0) begin
          ans.sample_value = set_vals[int'(rnd) % set_size];
          ans.ok           = 1'b1;
        end
      end
      default: begin
      end
    endcase
    ans.occupancy = OccW'(set_size);
    return ans;
  endfunction

  // Present one request and hold it until the block takes it. Called right
  // after a rising edge; leaves valid high so back-to-back transfers need no
  // extra edge.
  task automatic send_request(input logic [ReqW-1:0] kind, input logic [ValW-1:0] key,
                              input logic [RndW-1:0] rnd);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    value_i       <= key;
    random_word_i <= rnd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // Transfer happened at this edge: predict from the state it saw.
    answer_q.push_back(apply_request(kind, key, rnd));
  endtask

  // Edges and special cases on a small set, each outcome easy to follow.
  task automatic test_directed();
    send_request(REQ_SAMPLE, 32'h0, 16'hFFFF);          // sample of an empty set
    send_request(REQ_REMOVE, 32'h0, 16'h0);             // remove from an empty set
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);  // unused kind
    send_request(REQ_INSERT, 32'h8000_0000, 16'h0);
    send_request(REQ_INSERT, 32'h8000_0000, 16'h0);     // duplicate insert
    send_request(REQ_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
    send_request(REQ_INSERT, 32'h0, 16'h0);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 16'h0);
    send_request(REQ_SAMPLE, 32'hFFFF_FFFF, 16'h0);
    send_request(REQ_SAMPLE, 32'h0, 16'hFFFF);
    send_request(REQ_SAMPLE, 32'h5555_5555, 16'h2);
    send_request(REQ_REMOVE, 32'h8000_0000, 16'h0);     // first entry, last moves in
    send_request(REQ_SAMPLE, 32'h0, 16'h0);             // see the moved member
    send_request(REQ_REMOVE, 32'h0, 16'h0);             // remove of the last entry
    send_request(REQ_REMOVE, 32'h1234_5678, 16'h0);     // absent value
    send_request(REQ_UNUSED, 32'h0, 16'h0);             // unused kind, set not empty
    send_request(REQ_SAMPLE, 32'hAAAA_AAAA, 16'h1);
    send_request(REQ_REMOVE, 32'h7FFF_FFFF, 16'hFFFF);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 16'h0);
    send_request(REQ_SAMPLE, 32'h0, 16'h0);             // empty again
    send_request(REQ_INSERT, 32'h1, 16'h0);
    send_request(REQ_SAMPLE, 32'h0, 16'hFFFF);          // single member: any word picks it
    send_request(REQ_REMOVE, 32'h1, 16'h0);
  endtask

  // Fill to capacity, push against the limit, then drain in random order.
  task automatic test_full_store();
    logic [ValW-1:0] key;
    while (set_size < SET_CAP) send_request(REQ_INSERT, $urandom, 16'($urandom));
    send_request(REQ_INSERT, 32'h0BAD_CAFE, 16'h0);     // insert into a full store
    send_request(REQ_INSERT, set_vals[SET_CAP-1], 16'h0);
    send_request(REQ_SAMPLE, 32'h0, 16'hFFFF);
    send_request(REQ_SAMPLE, 32'h0, 16'h0);
    send_request(REQ_SAMPLE, 32'h0, 16'(SET_CAP - 1));
    while (set_size > 0) begin
      key = set_vals[$urandom_range(set_size - 1)];
      send_request(REQ_REMOVE, key, 16'($urandom));
      if ($urandom_range(3) == 0) send_request(REQ_SAMPLE, $urandom, 16'($urandom));
    end
    send_request(REQ_SAMPLE, 32'h0, 16'h0);
  endtask

  // Random mix over a pool of recurring values, so inserts collide, removes
  // hit, and the set swings between empty and full.
  task automatic test_random(input int n_items, input int insert_pct);
    logic [ValW-1:0] pool [96];
    logic [ValW-1:0] key;
    logic [RndW-1:0] rnd;
    int              roll;
    foreach (pool[i]) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0;
    pool[3] = 32'hFFFF_FFFF;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      rnd  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(SET_CAP + 8));
      key  = ($urandom_range(9) < 8) ? pool[$urandom_range(95)] : $urandom;
      if (roll < insert_pct) begin
        send_request(REQ_INSERT, key, rnd);
      end else if (roll < insert_pct + 30) begin
        // Mostly pick a live member; otherwise keep the key already drawn, hit or miss.
        if (set_size > 0 && $urandom_range(9) < 7) key = set_vals[$urandom_range(set_size - 1)];
        send_request(REQ_REMOVE, key, rnd);
      end else if (roll < 96) begin
        send_request(REQ_SAMPLE, key, rnd);
      end else begin
        send_request(REQ_UNUSED, key, rnd);
      end
    end
  endtask

  // Result side: stall at random, check every transfer against the oldest
  // pending answer.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $error("result with nothing pending: ok=%0b sample_value=%h occupancy=%0d",
               ok_o, sample_value_o, occupancy_o);
        fail_count++;
      end else begin
        want = answer_q.pop_front();
        if (ok_o !== want.ok) begin
          $error("ok: expected %0b, got %0b", want.ok, ok_o);
          fail_count++;
        end
        if (sample_value_o !== want.sample_value) begin
          $error("sample_value: expected %h, got %h", want.sample_value, sample_value_o);
          fail_count++;
        end
        if (occupancy_o !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, occupancy_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: drop the run if neither side moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sparse request gaps, heavy result stalls.
    send_gap_pct   = 8;
    recv_stall_pct = 77;
    test_directed();
    test_full_store();
    test_random(360, 45);

    // Phase two: swap the pressure.
    send_gap_pct   = 77;
    recv_stall_pct = 8;
    test_random(360, 35);

    // Phase three: full throughput on both sides.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(360, 40);

    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    // Hold a while longer so a stray extra result gets caught.
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
design/rset_pkg.sv
design/rset_mod.sv
design/randomized_set_table_top.sv
tb/tb_top.sv
